>>> rtl/rot_acc_pkg.sv
// Package: shared types, opcodes and helper functions for the rotation angle accumulator.
`timescale 1ns / 1ps
`default_nettype none

package rot_acc_pkg;

  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_SUB  = 2'd1;
  localparam logic [1:0] OP_LOAD = 2'd2;

  localparam logic signed [65:0] I32_MAX = 66'sd2147483647;
  localparam logic signed [65:0] I32_MIN = -66'sd2147483648;

  typedef struct packed {
    logic signed [31:0] turns;
    logic signed [31:0] cosine;
    logic signed [31:0] sine;
  } angle_t;

  typedef struct packed {
    logic signed [31:0] turns;
    logic signed [31:0] cosine;
    logic signed [31:0] sine;
    logic [1:0]         opcode;
  } item_t;

  // Saturate a wide signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > I32_MAX) begin
      r = 32'sh7fffffff;
    end else if (v < I32_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Nearest-cardinal index in -2..2, zero counted as positive.
  function automatic logic signed [2:0] cardinal_index(input logic signed [32:0] s,
                                                      input logic signed [32:0] c);
    logic signed [33:0] abs_s;
    logic signed [33:0] neg_c;
    logic signed [33:0] c_x;
    logic signed [2:0]  k;
    abs_s = s[32] ? -{s[32], s} : {s[32], s};
    neg_c = -{c[32], c};
    c_x   = {c[32], c};
    if (c[32]) begin
      k = (neg_c >= abs_s) ? 3'sd2 : 3'sd1;
    end else begin
      k = (c_x >= abs_s) ? 3'sd0 : 3'sd1;
    end
    return s[32] ? -k : k;
  endfunction

  // round(q / 4), ties away from zero.
  function automatic logic signed [2:0] round_quarter(input logic signed [4:0] q);
    logic signed [4:0] m;
    logic signed [4:0] r;
    if (!q[4]) begin
      m = q + 5'sd2;
      r = m >>> 2;
    end else begin
      m = 5'sd2 - q;
      r = -(m >>> 2);
    end
    return r[2:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/rot_acc_update.sv
// Single-pass update: rotate the accumulated vector and correct the turn count.
`timescale 1ns / 1ps
`default_nettype none

module rot_acc_update #(
  parameter int FRAC_BITS = 30
) (
  input  rot_acc_pkg::angle_t acc_i,
  input  rot_acc_pkg::item_t  item_i,
  output rot_acc_pkg::angle_t acc_o
);
  import rot_acc_pkg::*;

  localparam logic signed [64:0] Half = 65'sd1 <<< (FRAC_BITS - 1);

  logic signed [32:0] op_sine;
  logic signed [32:0] op_cos;
  logic signed [32:0] op_turns;
  logic signed [32:0] acc_sine_x;
  logic signed [32:0] acc_cos_x;

  logic signed [64:0] p_cc, p_ss, p_sc, p_cs;
  logic signed [64:0] r_cc, r_ss, r_sc, r_cs;
  logic signed [65:0] sum_cos, sum_sin;
  logic signed [31:0] new_sine, new_cos;
  logic signed [4:0]  q_sum;
  logic signed [2:0]  turn_fix;
  logic signed [65:0] turns_sum;

  always_comb begin
    acc_sine_x = {acc_i.sine[31], acc_i.sine};
    acc_cos_x  = {acc_i.cosine[31], acc_i.cosine};
    op_cos     = {item_i.cosine[31], item_i.cosine};
    if (item_i.opcode == OP_SUB) begin
      op_sine  = -{item_i.sine[31], item_i.sine};
      op_turns = -{item_i.turns[31], item_i.turns};
    end else begin
      op_sine  = {item_i.sine[31], item_i.sine};
      op_turns = {item_i.turns[31], item_i.turns};
    end
  end

  assign p_cc = 65'(acc_cos_x) * 65'(op_cos);
  assign p_ss = 65'(acc_sine_x) * 65'(op_sine);
  assign p_sc = 65'(acc_sine_x) * 65'(op_cos);
  assign p_cs = 65'(acc_cos_x) * 65'(op_sine);

  // Half-up rounding: add one half, arithmetic shift is a floor.
  assign r_cc = (p_cc + Half) >>> FRAC_BITS;
  assign r_ss = (p_ss + Half) >>> FRAC_BITS;
  assign r_sc = (p_sc + Half) >>> FRAC_BITS;
  assign r_cs = (p_cs + Half) >>> FRAC_BITS;

  assign sum_cos = {r_cc[64], r_cc} - {r_ss[64], r_ss};
  assign sum_sin = {r_sc[64], r_sc} + {r_cs[64], r_cs};

  assign new_cos  = sat32(sum_cos);
  assign new_sine = sat32(sum_sin);

  assign q_sum = 5'(cardinal_index(acc_sine_x, acc_cos_x))
               + 5'(cardinal_index(op_sine, op_cos))
               - 5'(cardinal_index({new_sine[31], new_sine}, {new_cos[31], new_cos}));

  assign turn_fix  = round_quarter(q_sum);
  assign turns_sum = 66'(acc_i.turns) + 66'(op_turns) + 66'(turn_fix);

  always_comb begin
    unique case (item_i.opcode)
      OP_ADD, OP_SUB: begin
        acc_o.sine   = new_sine;
        acc_o.cosine = new_cos;
        acc_o.turns  = sat32(turns_sum);
      end
      OP_LOAD: begin
        acc_o.sine   = item_i.sine;
        acc_o.cosine = item_i.cosine;
        acc_o.turns  = item_i.turns;
      end
      default: begin
        acc_o = acc_i;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/rotation_angle_accumulator.sv
// Top level: stream wrapper with input register and accumulator/result register.
`timescale 1ns / 1ps
`default_nettype none

// Rotation angle accumulator. Holds an angle as a unit vector (sine, cosine,
// 1.0 = 2^FRAC_BITS) plus a whole-turn count, reset to angle zero. Each
// input transfer adds, subtracts or loads an angle and yields exactly one
// output transfer carrying the accumulator after the update; an unused
// opcode returns the accumulator unchanged. Throughput is one item per
// cycle while the output is not stalled. An input transfer goes into the
// input register, then the update result into the result register that
// also holds the accumulator and raises output valid; a stalled output
// holds both. The cycle time is set by the update pass: four 32x33
// multiplies, the rounding adds, saturation and the cardinal compares
// between those two registers.

module rotation_angle_accumulator #(
  parameter int FRAC_BITS = 30
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output      logic         s_axis_tready,
  // opcode[1:0], in_sine[33:2], in_cosine[65:34], in_turns[97:66], zero pad
  input  wire logic [103:0] s_axis_tdata,
  output      logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // out_sine[31:0], out_cosine[63:32], out_turns[95:64]
  output      logic [95:0]  m_axis_tdata
);
  import rot_acc_pkg::*;

  logic   in_valid_q, in_valid_d;
  item_t  item_q;
  logic   out_valid_q, out_valid_d;
  angle_t acc_q, acc_d;
  logic   advance;
  logic   s_xfer;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  assign in_valid_d  = s_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d = advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  rot_acc_update #(
    .FRAC_BITS(FRAC_BITS)
  ) u_update (
    .acc_i (acc_q),
    .item_i(item_q),
    .acc_o (acc_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      acc_q.sine   <= '0;
      acc_q.cosine <= 32'sd1 <<< FRAC_BITS;
      acc_q.turns  <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        acc_q <= acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      item_q <= s_axis_tdata[97:0];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = acc_q;

  // Assertions
  a_adv_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> m_axis_tvalid)
    else $error("result register not valid after update");

  a_stall_acc : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(acc_q))
    else $error("accumulator changed while result stalled");

  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && m_axis_tvalid && !m_axis_tready) |=> (in_valid_q && $stable(item_q)))
    else $error("pending item lost during output stall");

  a_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && item_q.opcode == OP_LOAD) |=> (acc_q.sine == $past(item_q.sine)))
    else $error("load did not store operand");

endmodule

`default_nettype wire

>>> tb/rotation_angle_accumulator_test.sv
// Testbench: directed table plus random angle stream, checked against a cycle-free predictor.
`timescale 1ns / 1ps

module rotation_angle_accumulator_test;
  import rot_acc_pkg::*;

  localparam int FRAC = 30;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PER_PHASE = 333;
  localparam logic [1:0] OP_NONE = 2'd3;  // unused opcode, holds the accumulator
  localparam logic [31:0] ONE = 32'h4000_0000;
  localparam logic [31:0] NEG_ONE = 32'hc000_0000;
  localparam logic [31:0] DIAG = 32'h2d41_3ccd;      // 2^30 * sqrt(1/2)
  localparam logic [31:0] NEG_DIAG = 32'hd2be_c333;
  localparam longint WORD_MAX = 64'sd2147483647;
  localparam longint WORD_MIN = -64'sd2147483648;

  typedef struct packed {
    item_t  stim;
    logic   typed;
    angle_t want;
  } vector_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [95:0]  m_axis_tdata;

  angle_t  angle_acc;
  angle_t  expected_angles[$];
  vector_t directed_rows[$];
  int      mismatch_count = 0;
  int      cycle_count = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  logic    rx_hold = 1'b0;

  rotation_angle_accumulator #(.FRAC_BITS(FRAC)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // rounded product, half rounded up
  function automatic longint round_product(input longint a, input longint b);
    return (a * b + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
  endfunction

  function automatic longint clamp_word(input longint v);
    if (v > WORD_MAX) return WORD_MAX;
    if (v < WORD_MIN) return WORD_MIN;
    return v;
  endfunction

  // nearest cardinal direction, -2..2, zero counted as positive
  function automatic int nearest_cardinal(input longint s, input longint c);
    longint mag;
    int     k;
    mag = (s < 0) ? -s : s;
    if (c < 0) begin
      k = (-c >= mag) ? 2 : 1;
    end else begin
      k = (c >= mag) ? 0 : 1;
    end
    return (s < 0) ? -k : k;
  endfunction

  function automatic int quarter_round(input int q);
    if (q >= 0) return (q + 2) / 4;
    return -((-q + 2) / 4);
  endfunction

  function automatic angle_t rotate_angle(input angle_t a, input item_t it);
    longint as, ac, ps, pc, pn, ns, nc, nt;
    int     q;
    angle_t r;
    as = a.sine;
    ac = a.cosine;
    ps = it.sine;
    pc = it.cosine;
    pn = it.turns;
    r = a;
    case (it.opcode)
      OP_LOAD: begin
        r.sine = it.sine;
        r.cosine = it.cosine;
        r.turns = it.turns;
      end
      OP_ADD, OP_SUB: begin
        if (it.opcode == OP_SUB) begin
          ps = -ps;
          pn = -pn;
        end
        q = nearest_cardinal(as, ac) + nearest_cardinal(ps, pc);
        nc = clamp_word(round_product(ac, pc) - round_product(as, ps));
        ns = clamp_word(round_product(as, pc) + round_product(ac, ps));
        q = q - nearest_cardinal(ns, nc);
        nt = clamp_word(longint'(a.turns) + pn + quarter_round(q));
        r.sine = ns[31:0];
        r.cosine = nc[31:0];
        r.turns = nt[31:0];
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic vector_t row(input logic [1:0] op, input logic [31:0] s,
                                  input logic [31:0] c, input logic [31:0] t,
                                  input logic typed = 1'b0, input logic [31:0] ws = '0,
                                  input logic [31:0] wc = '0, input logic [31:0] wt = '0);
    vector_t v;
    v.stim.opcode = op;
    v.stim.sine = s;
    v.stim.cosine = c;
    v.stim.turns = t;
    v.typed = typed;
    v.want.sine = ws;
    v.want.cosine = wc;
    v.want.turns = wt;
    return v;
  endfunction

  function automatic logic [31:0] odd_word();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return ONE;
      3: return NEG_ONE;
      4: return 32'h0;
      default: return $urandom();
    endcase
  endfunction

  function automatic item_t make_angle();
    item_t it;
    real   ang;
    int    pick;
    int    mode;
    pick = $urandom_range(99);
    if (pick < 45) begin
      it.opcode = OP_ADD;
    end else if (pick < 80) begin
      it.opcode = OP_SUB;
    end else if (pick < 93) begin
      it.opcode = OP_LOAD;
    end else begin
      it.opcode = OP_NONE;
    end
    mode = $urandom_range(99);
    if (mode < 75) begin
      ang = real'($urandom_range(65535)) * 6.283185307179586 / 65536.0;
      it.sine = $rtoi(1073741824.0 * $sin(ang));
      it.cosine = $rtoi(1073741824.0 * $cos(ang));
    end else if (mode < 85) begin
      case ($urandom_range(3))
        0: begin it.sine = 32'h0; it.cosine = ONE; end
        1: begin it.sine = ONE; it.cosine = 32'h0; end
        2: begin it.sine = 32'h0; it.cosine = NEG_ONE; end
        default: begin it.sine = NEG_ONE; it.cosine = 32'h0; end
      endcase
    end else begin
      it.sine = odd_word();
      it.cosine = odd_word();
    end
    if ($urandom_range(99) < 80) begin
      it.turns = int'($urandom_range(8)) - 4;
    end else begin
      it.turns = odd_word();
    end
    return it;
  endfunction

  // entered and left at a falling edge
  task automatic offer(input item_t it, input logic typed, input angle_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, it};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    angle_acc = rotate_angle(angle_acc, it);
    expected_angles.push_back(typed ? want : angle_acc);
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin : result_check
    angle_t got;
    angle_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_angles.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: sine %h cosine %h turns %h",
                   got.sine, got.cosine, got.turns);
      end else begin
        want = expected_angles.pop_front();
        if (got.sine !== want.sine || got.cosine !== want.cosine ||
            got.turns !== want.turns) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch (exp/got): sine %h/%h cosine %h/%h turns %h/%h",
                     want.sine, got.sine, want.cosine, got.cosine,
                     want.turns, got.turns);
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    int idle_plan[4];
    int stall_plan[4];
    idle_plan = '{0, 85, 0, 32};
    stall_plan = '{0, 0, 85, 32};
    angle_acc.sine = 32'h0;
    angle_acc.cosine = ONE;
    angle_acc.turns = 32'h0;

    directed_rows.push_back(row(OP_NONE, '1, '1, '1, 1'b1, 32'h0, ONE, 32'h0));
    directed_rows.push_back(row(OP_ADD, 32'h0, ONE, 32'h0, 1'b1, 32'h0, ONE, 32'h0));
    directed_rows.push_back(row(OP_ADD, ONE, 32'h0, 32'h0));
    directed_rows.push_back(row(OP_ADD, ONE, 32'h0, 32'h0));
    directed_rows.push_back(row(OP_ADD, ONE, 32'h0, 32'h0));
    directed_rows.push_back(row(OP_ADD, ONE, 32'h0, 32'h0));
    directed_rows.push_back(row(OP_SUB, ONE, 32'h0, 32'h0));
    directed_rows.push_back(row(OP_SUB, ONE, 32'h0, 32'h0));
    directed_rows.push_back(row(OP_LOAD, ONE, 32'h0, 32'd5, 1'b1, ONE, 32'h0, 32'd5));
    directed_rows.push_back(row(OP_LOAD, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                                1'b1, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff));
    directed_rows.push_back(row(OP_ADD, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0));
    directed_rows.push_back(row(OP_SUB, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    // turn saturation, both directions, and negation of the minimum
    directed_rows.push_back(row(OP_LOAD, 32'h0, ONE, 32'h7fff_ffff,
                                1'b1, 32'h0, ONE, 32'h7fff_ffff));
    directed_rows.push_back(row(OP_ADD, 32'h0, ONE, 32'h7fff_ffff,
                                1'b1, 32'h0, ONE, 32'h7fff_ffff));
    directed_rows.push_back(row(OP_LOAD, 32'h0, ONE, 32'h8000_0000,
                                1'b1, 32'h0, ONE, 32'h8000_0000));
    directed_rows.push_back(row(OP_ADD, 32'h0, ONE, 32'h8000_0000,
                                1'b1, 32'h0, ONE, 32'h8000_0000));
    directed_rows.push_back(row(OP_SUB, 32'h0, ONE, 32'h8000_0000,
                                1'b1, 32'h0, ONE, 32'h0));
    directed_rows.push_back(row(OP_LOAD, 32'h0, NEG_ONE, 32'h0, 1'b1, 32'h0, NEG_ONE, 32'h0));
    directed_rows.push_back(row(OP_ADD, 32'h0, NEG_ONE, 32'h0));
    directed_rows.push_back(row(OP_ADD, DIAG, DIAG, 32'h0));
    directed_rows.push_back(row(OP_ADD, DIAG, NEG_DIAG, 32'hffff_ffff));
    directed_rows.push_back(row(OP_SUB, NEG_DIAG, NEG_DIAG, 32'd3));
    directed_rows.push_back(row(OP_LOAD, 32'hffff_ffff, 32'h1, 32'h0,
                                1'b1, 32'hffff_ffff, 32'h1, 32'h0));
    directed_rows.push_back(row(OP_NONE, 32'h0, 32'h0, 32'h0,
                                1'b1, 32'hffff_ffff, 32'h1, 32'h0));

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i])
      offer(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_plan[p];
      recv_stall_pct = stall_plan[p];
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (p == 0 && n == 100) begin
          // long output hold-off so the pipeline backs up into the input
          fork
            begin
              rx_hold = 1'b1;
              repeat (300) @(negedge clk_i);
              rx_hold = 1'b0;
            end
          join_none
        end
        offer(make_angle(), 1'b0, '0);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (expected_angles.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
